// ----- hw/rtl/ajd_pkg.sv -----
// ----------------------------------------------------------------------------
// ajd_pkg: shared types, constants and fixed-point helpers
// Stage records, register indexes and the saturating Q-format arithmetic
// used along the joint dynamics pipeline.
// ----------------------------------------------------------------------------
package ajd_pkg;

    localparam int SINE_TABLE_DEPTH_DEF = 1024;
    localparam int FRACTION_BITS_DEF    = 16;

    localparam int REG_COUNT  = 8;
    localparam int REG_W      = 31;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_FIRST_LINK_MASS    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SECOND_LINK_MASS   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_COM_DISTANCE = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_LINK_LENGTH  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SECOND_COM_DISTANCE = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FIRST_INERTIA_ZZ   = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_SECOND_INERTIA_ZZ  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_GRAVITY_ACCEL      = 3'd7;

    localparam logic [REG_W-1:0] GRAVITY_RESET = 31'd642908;

    localparam logic signed [63:0] INV_TWO_PI_Q32 = 64'sd683565276;
    localparam logic [63:0]        HALF_PI_Q30    = 64'd1686629713;

    // Taylor series divisors (2k)(2k+1) for k = 1..7
    localparam logic [63:0] SERIES_DIV [1:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156, 64'd210};

    typedef struct packed {
        logic signed [31:0] az;
        logic signed [31:0] el;
        logic signed [31:0] rate1;
        logic signed [31:0] rate2;
        logic signed [17:0] rx;
        logic signed [17:0] ry;
        logic signed [17:0] rz;
    } st0_t;

    typedef struct packed {
        logic [31:0]        ph1;
        logic [31:0]        ph2;
        logic signed [31:0] d;
        logic signed [31:0] a1;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] gz;
        logic signed [31:0] iz;
        logic signed [31:0] rate1;
        logic signed [31:0] rate2;
    } st1_t;

    typedef struct packed {
        logic [1:0]         quad1;
        logic [1:0]         quad2;
        logic signed [31:0] a1;
        logic signed [31:0] d;
        logic signed [31:0] a2;
        logic signed [31:0] a1lc;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] gz;
        logic signed [31:0] iz;
        logic signed [31:0] rate1;
        logic signed [31:0] rate2;
    } st2_t;

    typedef struct packed {
        logic signed [31:0] s1;
        logic signed [31:0] c1;
        logic signed [31:0] s2;
        logic signed [31:0] c2;
        logic signed [31:0] a2d;
        logic signed [31:0] k1;
        logic signed [31:0] a1lc;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
        logic signed [31:0] gz;
        logic signed [31:0] iz;
        logic signed [31:0] rate1;
        logic signed [31:0] rate2;
    } st3_t;

    typedef struct packed {
        logic signed [31:0] k2;
        logic signed [31:0] s2;
        logic signed [31:0] c2;
        logic signed [31:0] k1;
        logic signed [31:0] k1s2;
        logic signed [31:0] gyc1;
        logic signed [31:0] gxs1;
        logic signed [31:0] gxc1;
        logic signed [31:0] gys1;
        logic signed [31:0] gzs2;
        logic signed [31:0] iz;
        logic signed [31:0] rate1;
        logic signed [31:0] rate2;
    } st4_t;

    typedef struct packed {
        logic signed [31:0] k2s;
        logic signed [31:0] s2;
        logic signed [31:0] c2;
        logic signed [31:0] m22;
        logic signed [31:0] t1;
        logic signed [31:0] k1s2;
        logic signed [31:0] k1;
        logic signed [31:0] gxc1c2;
        logic signed [31:0] gys1c2;
        logic signed [31:0] gzs2;
        logic signed [31:0] iz;
        logic signed [31:0] rate1;
        logic signed [31:0] rate2;
    } st5_t;

    typedef struct packed {
        logic signed [31:0] m11p;
        logic signed [31:0] h;
        logic signed [31:0] tau1;
        logic signed [31:0] t2;
        logic signed [31:0] m22;
        logic signed [31:0] k1;
        logic signed [31:0] iz;
        logic signed [31:0] rate1;
        logic signed [31:0] rate2;
    } st6_t;

    typedef struct packed {
        logic signed [31:0] m11;
        logic signed [31:0] m22;
        logic signed [31:0] ca;
        logic signed [31:0] cb;
        logic signed [31:0] cc;
        logic signed [31:0] tau1;
        logic signed [31:0] tau2;
    } st7_t;

    // Clamp a wide signed value to 32 bits
    function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] add_s(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return sat64(64'(a) + 64'(b));
    endfunction

    function automatic logic signed [31:0] sub_s(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return sat64(64'(a) - 64'(b));
    endfunction

    function automatic logic signed [31:0] neg_s(input logic signed [31:0] a);
        return sat64(-64'(a));
    endfunction

    // Product with half-LSB offset, floor shift and saturation
    function automatic logic signed [31:0] mul_q(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input int frac);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        p = p + (64'sd1 <<< (frac - 1));
        return sat64(p >>> frac);
    endfunction

    // Turn fraction of an angle in radians
    function automatic logic [31:0] angle_phase(input logic signed [31:0] angle,
                                                input int frac);
        logic signed [63:0] p;
        p = 64'(angle) * INV_TWO_PI_Q32;
        return p[frac +: 32];
    endfunction

    // Odd series for sine of a Q30 angle, clamped to [0, 1.0]
    function automatic logic signed [63:0] sine_series(input logic [63:0] x);
        logic [63:0]        term;
        logic signed [63:0] sum;
        term = x;
        sum  = $signed(x);
        for (int k = 1; k <= 7; k++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / SERIES_DIV[k];
            if (k % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > (64'sd1 <<< 30))
            sum = 64'sd1 <<< 30;
        return sum;
    endfunction

endpackage

// ----- hw/rtl/ajd_ram.sv -----
// ----------------------------------------------------------------------------
// ajd_ram: generic RAM
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module ajd_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1025
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // Registered reads, held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

// ----- hw/rtl/ajd_cell.sv -----
// ----------------------------------------------------------------------------
// ajd_cell: pipeline cell
// Holds one request's partial results and hands them to the next cell.
// ----------------------------------------------------------------------------
module ajd_cell #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_vld,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_vld,
    output logic [WIDTH-1:0] out_data
);

    logic             valid_reg;
    logic [WIDTH-1:0] data_reg;

    // Advance valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_vld;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
            data_reg <= in_data;
    end

    assign out_vld  = valid_reg;
    assign out_data = data_reg;

endmodule

// ----- hw/rtl/arm_joint_dynamics_terms.sv -----
// ----------------------------------------------------------------------------
// arm_joint_dynamics_terms: joint-space dynamics of a two-joint arm
// Mass diagonal, Coriolis entries and gravity torques in saturated Q format.
// ----------------------------------------------------------------------------
// The block takes one joint state per clock cycle while in_stall is low and
// presents its terms on the output ports after the chain of eight pipeline
// cells (the first registers the request), with at most one multiplier per
// path in each. After reset the quarter-wave sine table is loaded into two
// RAMs, one entry per cycle, SINE_TABLE_DEPTH+1 entries in all;
// in_stall stays high during that load. An input skid register lets one
// request in while the result at the output is held by out_stall.
module arm_joint_dynamics_terms #(
    parameter int SINE_TABLE_DEPTH = ajd_pkg::SINE_TABLE_DEPTH_DEF,
    parameter int FRACTION_BITS    = ajd_pkg::FRACTION_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [ajd_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [ajd_pkg::REG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [31:0]          azimuth_angle,
    input  logic signed [31:0]          elevation_angle,
    input  logic signed [31:0]          azimuth_rate,
    input  logic signed [31:0]          elevation_rate,
    input  logic signed [17:0]          rot_row_x,
    input  logic signed [17:0]          rot_row_y,
    input  logic signed [17:0]          rot_row_z,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [31:0]          mass_azimuth,
    output logic signed [31:0]          mass_elevation,
    output logic signed [31:0]          coriolis_a,
    output logic signed [31:0]          coriolis_b,
    output logic signed [31:0]          coriolis_c,
    output logic signed [31:0]          gravity_torque_azimuth,
    output logic signed [31:0]          gravity_torque_elevation
);

    localparam int IW    = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int TW    = FRACTION_BITS + 1;
    localparam int STAGES = 8;

    typedef logic [TW-1:0] rom_t [SINE_TABLE_DEPTH+1];

    // Table contents, worked out at elaboration
    function automatic rom_t build_rom();
        rom_t               t;
        logic [63:0]        x;
        logic signed [63:0] s;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++)
        begin
            x = (ajd_pkg::HALF_PI_Q30 * 64'(i) + 64'(SINE_TABLE_DEPTH / 2))
                / 64'(SINE_TABLE_DEPTH);
            s = ajd_pkg::sine_series(x);
            s = (s + (64'sd1 <<< (29 - FRACTION_BITS))) >>> (30 - FRACTION_BITS);
            t[i] = s[TW-1:0];
        end
        return t;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    logic [ajd_pkg::REG_W-1:0] cfg_reg [ajd_pkg::REG_COUNT];
    logic                      fill_busy_reg;
    logic [IW-1:0]             fill_cnt_reg;
    logic                      skid_valid_reg;
    logic                      skid_valid_next;
    ajd_pkg::st0_t             skid_data_reg;
    ajd_pkg::st0_t             in_item;
    logic                      in_accept;
    logic                      adv;

    logic [STAGES-1:0] vld;
    ajd_pkg::st0_t     r0, n0;
    ajd_pkg::st1_t     r1, n1;
    ajd_pkg::st2_t     r2, n2;
    ajd_pkg::st3_t     r3, n3;
    ajd_pkg::st4_t     r4, n4;
    ajd_pkg::st5_t     r5, n5;
    ajd_pkg::st6_t     r6, n6;
    ajd_pkg::st7_t     r7, n7;
    logic              v0_in;

    logic signed [31:0] m1, m2, lc1, l1, lc2, i1, i2, gacc;

    logic [47:0]   idx1_prod, idx2_prod;
    logic [IW-1:0] idx1, idx2, ridx1, ridx2;
    logic [TW-1:0] t1a, t1b, t2a, t2b;
    logic [1:0]    cq1, cq2;
    logic [31:0]   v_s1, v_c1, v_s2, v_c2;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ajd_pkg::REG_COUNT; k++)
                cfg_reg[k] <= (k == int'(ajd_pkg::REG_GRAVITY_ACCEL))
                              ? ajd_pkg::GRAVITY_RESET : '0;
        end
        else if (cfg_write)
            cfg_reg[cfg_index] <= cfg_data;
    end

    assign m1   = 32'(cfg_reg[ajd_pkg::REG_FIRST_LINK_MASS]);
    assign m2   = 32'(cfg_reg[ajd_pkg::REG_SECOND_LINK_MASS]);
    assign lc1  = 32'(cfg_reg[ajd_pkg::REG_FIRST_COM_DISTANCE]);
    assign l1   = 32'(cfg_reg[ajd_pkg::REG_FIRST_LINK_LENGTH]);
    assign lc2  = 32'(cfg_reg[ajd_pkg::REG_SECOND_COM_DISTANCE]);
    assign i1   = 32'(cfg_reg[ajd_pkg::REG_FIRST_INERTIA_ZZ]);
    assign i2   = 32'(cfg_reg[ajd_pkg::REG_SECOND_INERTIA_ZZ]);
    assign gacc = 32'(cfg_reg[ajd_pkg::REG_GRAVITY_ACCEL]);

    // Load the sine table after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_busy_reg <= 1'b1;
            fill_cnt_reg  <= '0;
        end
        else if (fill_busy_reg)
        begin
            if (fill_cnt_reg == IW'(SINE_TABLE_DEPTH))
                fill_busy_reg <= 1'b0;
            else
                fill_cnt_reg <= fill_cnt_reg + 1'b1;
        end
    end

    // Input handshake and skid register
    assign adv       = !(out_valid && out_stall);
    assign in_stall  = fill_busy_reg || skid_valid_reg;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_item.az    = azimuth_angle;
        in_item.el    = elevation_angle;
        in_item.rate1 = azimuth_rate;
        in_item.rate2 = elevation_rate;
        in_item.rx    = rot_row_x;
        in_item.ry    = rot_row_y;
        in_item.rz    = rot_row_z;
    end

    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        if (adv)
            skid_valid_next = 1'b0;
        else if (in_accept)
            skid_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_valid_reg <= 1'b0;
        else
            skid_valid_reg <= skid_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (!adv && in_accept)
            skid_data_reg <= in_item;
    end

    assign v0_in = skid_valid_reg || in_accept;
    assign n0    = skid_valid_reg ? skid_data_reg : in_item;

    // Phases, link offset, first moment, body gravity, inertia sum
    always_comb
    begin
        n1.ph1   = ajd_pkg::angle_phase(r0.az, FRACTION_BITS);
        n1.ph2   = ajd_pkg::angle_phase(r0.el, FRACTION_BITS);
        n1.d     = ajd_pkg::add_s(l1, lc2);
        n1.a1    = ajd_pkg::mul_q(m1, lc1, FRACTION_BITS);
        n1.gx    = ajd_pkg::neg_s(ajd_pkg::mul_q(gacc, 32'(r0.rx), FRACTION_BITS));
        n1.gy    = ajd_pkg::neg_s(ajd_pkg::mul_q(gacc, 32'(r0.ry), FRACTION_BITS));
        n1.gz    = ajd_pkg::neg_s(ajd_pkg::mul_q(gacc, 32'(r0.rz), FRACTION_BITS));
        n1.iz    = ajd_pkg::add_s(i1, i2);
        n1.rate1 = r0.rate1;
        n1.rate2 = r0.rate2;
    end

    // Table addresses from the phase remainder
    assign idx1_prod = {18'd0, r1.ph1[29:0]} * 48'(SINE_TABLE_DEPTH);
    assign idx2_prod = {18'd0, r1.ph2[29:0]} * 48'(SINE_TABLE_DEPTH);
    assign idx1      = idx1_prod[30 +: IW];
    assign idx2      = idx2_prod[30 +: IW];
    assign ridx1     = IW'(SINE_TABLE_DEPTH) - idx1;
    assign ridx2     = IW'(SINE_TABLE_DEPTH) - idx2;

    ajd_ram #(
        .WIDTH (TW),
        .DEPTH (SINE_TABLE_DEPTH + 1)
    ) u_table_az (
        .clk     (clk),
        .we      (fill_busy_reg),
        .waddr   (fill_cnt_reg),
        .wdata   (SINE_ROM[fill_cnt_reg]),
        .re      (adv),
        .raddr_a (idx1),
        .raddr_b (ridx1),
        .rdata_a (t1a),
        .rdata_b (t1b)
    );

    ajd_ram #(
        .WIDTH (TW),
        .DEPTH (SINE_TABLE_DEPTH + 1)
    ) u_table_el (
        .clk     (clk),
        .we      (fill_busy_reg),
        .waddr   (fill_cnt_reg),
        .wdata   (SINE_ROM[fill_cnt_reg]),
        .re      (adv),
        .raddr_a (idx2),
        .raddr_b (ridx2),
        .rdata_a (t2a),
        .rdata_b (t2b)
    );

    // Second link moment and first link second moment
    always_comb
    begin
        n2.quad1 = r1.ph1[31:30];
        n2.quad2 = r1.ph2[31:30];
        n2.a1    = r1.a1;
        n2.d     = r1.d;
        n2.a2    = ajd_pkg::mul_q(m2, r1.d, FRACTION_BITS);
        n2.a1lc  = ajd_pkg::mul_q(r1.a1, lc1, FRACTION_BITS);
        n2.gx    = r1.gx;
        n2.gy    = r1.gy;
        n2.gz    = r1.gz;
        n2.iz    = r1.iz;
        n2.rate1 = r1.rate1;
        n2.rate2 = r1.rate2;
    end

    // Fold quadrants into sine and cosine
    assign cq1  = r2.quad1 + 2'd1;
    assign cq2  = r2.quad2 + 2'd1;
    assign v_s1 = 32'(r2.quad1[0] ? t1b : t1a);
    assign v_c1 = 32'(cq1[0] ? t1b : t1a);
    assign v_s2 = 32'(r2.quad2[0] ? t2b : t2a);
    assign v_c2 = 32'(cq2[0] ? t2b : t2a);

    always_comb
    begin
        n3.s1    = r2.quad1[1] ? -$signed(v_s1) : $signed(v_s1);
        n3.c1    = cq1[1] ? -$signed(v_c1) : $signed(v_c1);
        n3.s2    = r2.quad2[1] ? -$signed(v_s2) : $signed(v_s2);
        n3.c2    = cq2[1] ? -$signed(v_c2) : $signed(v_c2);
        n3.a2d   = ajd_pkg::mul_q(r2.a2, r2.d, FRACTION_BITS);
        n3.k1    = ajd_pkg::add_s(r2.a1, r2.a2);
        n3.a1lc  = r2.a1lc;
        n3.gx    = r2.gx;
        n3.gy    = r2.gy;
        n3.gz    = r2.gz;
        n3.iz    = r2.iz;
        n3.rate1 = r2.rate1;
        n3.rate2 = r2.rate2;
    end

    // Second moment sum and gravity projections
    always_comb
    begin
        n4.k2    = ajd_pkg::add_s(r3.a1lc, r3.a2d);
        n4.s2    = r3.s2;
        n4.c2    = r3.c2;
        n4.k1    = r3.k1;
        n4.k1s2  = ajd_pkg::mul_q(r3.k1, r3.s2, FRACTION_BITS);
        n4.gyc1  = ajd_pkg::mul_q(r3.gy, r3.c1, FRACTION_BITS);
        n4.gxs1  = ajd_pkg::mul_q(r3.gx, r3.s1, FRACTION_BITS);
        n4.gxc1  = ajd_pkg::mul_q(r3.gx, r3.c1, FRACTION_BITS);
        n4.gys1  = ajd_pkg::mul_q(r3.gy, r3.s1, FRACTION_BITS);
        n4.gzs2  = ajd_pkg::mul_q(r3.gz, r3.s2, FRACTION_BITS);
        n4.iz    = r3.iz;
        n4.rate1 = r3.rate1;
        n4.rate2 = r3.rate2;
    end

    always_comb
    begin
        n5.k2s    = ajd_pkg::mul_q(r4.k2, r4.s2, FRACTION_BITS);
        n5.s2     = r4.s2;
        n5.c2     = r4.c2;
        n5.m22    = ajd_pkg::add_s(r4.k2, r4.iz);
        n5.t1     = ajd_pkg::sub_s(r4.gyc1, r4.gxs1);
        n5.k1s2   = r4.k1s2;
        n5.k1     = r4.k1;
        n5.gxc1c2 = ajd_pkg::mul_q(r4.gxc1, r4.c2, FRACTION_BITS);
        n5.gys1c2 = ajd_pkg::mul_q(r4.gys1, r4.c2, FRACTION_BITS);
        n5.gzs2   = r4.gzs2;
        n5.iz     = r4.iz;
        n5.rate1  = r4.rate1;
        n5.rate2  = r4.rate2;
    end

    // Mass product, Coriolis factor, first torque, second torque sum
    always_comb
    begin
        n6.m11p  = ajd_pkg::mul_q(r5.k2s, r5.s2, FRACTION_BITS);
        n6.h     = ajd_pkg::mul_q(r5.k2s, r5.c2, FRACTION_BITS);
        n6.tau1  = ajd_pkg::neg_s(ajd_pkg::mul_q(r5.k1s2, r5.t1, FRACTION_BITS));
        n6.t2    = ajd_pkg::sat64(64'(r5.gxc1c2) + 64'(r5.gys1c2) + 64'(r5.gzs2));
        n6.m22   = r5.m22;
        n6.k1    = r5.k1;
        n6.iz    = r5.iz;
        n6.rate1 = r5.rate1;
        n6.rate2 = r5.rate2;
    end

    always_comb
    begin
        n7.m11  = ajd_pkg::add_s(r6.m11p, r6.iz);
        n7.m22  = r6.m22;
        n7.ca   = ajd_pkg::mul_q(r6.h, r6.rate2, FRACTION_BITS);
        n7.cb   = ajd_pkg::mul_q(r6.h, r6.rate1, FRACTION_BITS);
        n7.cc   = ajd_pkg::neg_s(ajd_pkg::mul_q(r6.h, r6.rate1, FRACTION_BITS));
        n7.tau1 = r6.tau1;
        n7.tau2 = ajd_pkg::neg_s(ajd_pkg::mul_q(r6.k1, r6.t2, FRACTION_BITS));
    end

    // Chain of cells
    ajd_cell #(.WIDTH($bits(ajd_pkg::st0_t))) u_cell0 (
        .clk (clk), .rst_n (rst_n), .adv (adv),
        .in_vld (v0_in), .in_data (n0), .out_vld (vld[0]), .out_data (r0)
    );
    ajd_cell #(.WIDTH($bits(ajd_pkg::st1_t))) u_cell1 (
        .clk (clk), .rst_n (rst_n), .adv (adv),
        .in_vld (vld[0]), .in_data (n1), .out_vld (vld[1]), .out_data (r1)
    );
    ajd_cell #(.WIDTH($bits(ajd_pkg::st2_t))) u_cell2 (
        .clk (clk), .rst_n (rst_n), .adv (adv),
        .in_vld (vld[1]), .in_data (n2), .out_vld (vld[2]), .out_data (r2)
    );
    ajd_cell #(.WIDTH($bits(ajd_pkg::st3_t))) u_cell3 (
        .clk (clk), .rst_n (rst_n), .adv (adv),
        .in_vld (vld[2]), .in_data (n3), .out_vld (vld[3]), .out_data (r3)
    );
    ajd_cell #(.WIDTH($bits(ajd_pkg::st4_t))) u_cell4 (
        .clk (clk), .rst_n (rst_n), .adv (adv),
        .in_vld (vld[3]), .in_data (n4), .out_vld (vld[4]), .out_data (r4)
    );
    ajd_cell #(.WIDTH($bits(ajd_pkg::st5_t))) u_cell5 (
        .clk (clk), .rst_n (rst_n), .adv (adv),
        .in_vld (vld[4]), .in_data (n5), .out_vld (vld[5]), .out_data (r5)
    );
    ajd_cell #(.WIDTH($bits(ajd_pkg::st6_t))) u_cell6 (
        .clk (clk), .rst_n (rst_n), .adv (adv),
        .in_vld (vld[5]), .in_data (n6), .out_vld (vld[6]), .out_data (r6)
    );
    ajd_cell #(.WIDTH($bits(ajd_pkg::st7_t))) u_cell7 (
        .clk (clk), .rst_n (rst_n), .adv (adv),
        .in_vld (vld[6]), .in_data (n7), .out_vld (vld[7]), .out_data (r7)
    );

    // Drive result ports from the last cell
    assign out_valid                = vld[STAGES-1];
    assign mass_azimuth             = r7.m11;
    assign mass_elevation           = r7.m22;
    assign coriolis_a               = r7.ca;
    assign coriolis_b               = r7.cb;
    assign coriolis_c               = r7.cc;
    assign gravity_torque_azimuth   = r7.tau1;
    assign gravity_torque_elevation = r7.tau2;

endmodule

// ----- hw/rtl/ajd_checker.sv -----
// ----------------------------------------------------------------------------
// ajd_checker: port-level checks for the joint dynamics block
// Watches the handshakes and the result relations on the top-level ports.
// ----------------------------------------------------------------------------
module ajd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] mass_azimuth,
    input logic signed [31:0] coriolis_b,
    input logic signed [31:0] coriolis_c
);

    // Hold a stalled result
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(mass_azimuth) && $stable(coriolis_b))
        else $error("stalled result changed");

    // C21 is the saturated negation of C12
    a_coriolis_neg: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (coriolis_c == -coriolis_b)
                   || (coriolis_b == 32'sh80000000 && coriolis_c == 32'sh7FFFFFFF))
        else $error("coriolis_c is not minus coriolis_b");

    // Requests are stalled when reset is released, as the sine table load begins
    a_reset_stall: assert property (@(posedge clk)
        $past(!rst_n) && rst_n |-> in_stall)
        else $error("request accepted during table load");

endmodule

bind arm_joint_dynamics_terms ajd_checker u_checker (.*);
